@@ design/fhu_pkg.sv @@
// Shared types and constants for the single-precision hypotenuse unit.
// Used by fhu_sqrt and float_hypot_unit; depends on nothing.
package fhu_pkg;

    localparam logic [30:0] C_INF      = 31'h7f800000;
    localparam logic [30:0] C_FAR      = 31'h0c800000;
    localparam logic [31:0] C_QUIET    = 32'h00400000;
    localparam int          C_SQ_STEPS = 53;

    typedef struct packed {
        logic [31:0] x_bits;
        logic [31:0] y_bits;
        logic        last_item;
    } t_in;

    typedef struct packed {
        logic [31:0] z_bits;
        logic        last_out;
    } t_out;

    // Normalized operand: value = man * 2^ex, man[23] set for nonzero input
    typedef struct packed {
        logic signed [9:0] ex;
        logic [23:0]       man;
    } t_op;

    // Fields that ride alongside the root recurrence
    typedef struct packed {
        logic              last;
        logic              fast;
        logic [31:0]       fast_z;
        logic signed [11:0] half;
    } t_side;

    function automatic logic [4:0] lzc24(input logic [23:0] v);
        logic [4:0] n;
        n = 5'd24;
        for (int i = 0; i < 24; i++) begin
            if (v[i]) n = 5'(23 - i);
        end
        return n;
    endfunction

endpackage

@@ design/float_hypot_unit.sv @@
// Single-precision hypotenuse: z = sqrt(x*x + y*y) on binary32 patterns.
// Depends on fhu_pkg and fhu_sqrt.
//
// Input channel: i_valid / o_stall carry i_data (x_bits, y_bits, last_item).
// Output channel: o_valid / i_stall carry o_data (z_bits, last_out).
// An item moves on a clock edge where valid is high and stall is low.
// Throughput: one item per cycle while o_stall is low. A taken item passes
// 5 front stages for classify, normalize, square, add and binary64
// round; 53 root stages, one result bit each; 2 stages of root rounding
// and binary32 packing; then the output reg, which drives o_valid.
// Fast cases (zero, far apart, infinity, NaN) ride the same pipeline so
// results keep their order.
// When the receiver stalls, the output register holds and a one-entry skid
// register takes the next result; o_stall rises only while the skid is
// full, and then the whole pipeline holds in place.
// Reset (synchronous, active low) empties every stage; no clearing pass.
module float_hypot_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  fhu_pkg::t_in  i_data,
    output logic          o_valid,
    input  logic          i_stall,
    output fhu_pkg::t_out o_data
);

    function automatic fhu_pkg::t_op norm_op(input logic [30:0] p);
        fhu_pkg::t_op o;
        logic [23:0]  raw;
        logic [4:0]   lz;
        raw = {1'b0, p[22:0]};
        lz  = fhu_pkg::lzc24(raw);
        if (p[30:23] != 8'd0) begin
            o.man = {1'b1, p[22:0]};
            o.ex  = $signed({2'b00, p[30:23]}) - 10'sd150;
        end else begin
            o.man = raw << lz;
            o.ex  = -10'sd149 - $signed({5'b00000, lz});
        end
        return o;
    endfunction

    logic w_en;
    logic w_out_free;

    // ---------------- stage 1: classify, fast result ----------------
    logic [30:0] w_ax, w_ay, w_big, w_small, w_diff;
    logic        w_fast;
    logic [31:0] w_fz;

    assign w_ax    = i_data.x_bits[30:0];
    assign w_ay    = i_data.y_bits[30:0];
    assign w_big   = (w_ax > w_ay) ? w_ax : w_ay;
    assign w_small = (w_ax > w_ay) ? w_ay : w_ax;
    assign w_diff  = w_big - w_small;
    assign w_fast  = (w_ax == '0) || (w_ay == '0) || (w_diff >= fhu_pkg::C_FAR) ||
                     (w_big[30:23] == 8'hff);

    always_comb begin
        if (w_ax == fhu_pkg::C_INF || w_ay == fhu_pkg::C_INF) begin
            w_fz = {1'b0, fhu_pkg::C_INF};
        end else if (w_ax > fhu_pkg::C_INF) begin
            w_fz = i_data.x_bits | fhu_pkg::C_QUIET;
        end else if (w_ay > fhu_pkg::C_INF) begin
            w_fz = i_data.y_bits | fhu_pkg::C_QUIET;
        end else begin
            // zero operand or far apart: the smaller is below half an ulp of the larger
            w_fz = {1'b0, w_big};
        end
    end

    logic        r_v1, r_fast1, r_last1;
    logic [30:0] r_big1, r_small1;
    logic [31:0] r_fz1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_big1   <= w_big;
            r_small1 <= w_small;
            r_fast1  <= w_fast;
            r_fz1    <= w_fz;
            r_last1  <= i_data.last_item;
        end
    end

    // ---------------- stage 2: normalize mantissas ----------------
    fhu_pkg::t_op w_ob, w_os;
    assign w_ob = norm_op(r_big1);
    assign w_os = norm_op(r_small1);

    logic              r_v2, r_fast2, r_last2;
    logic [31:0]       r_fz2;
    logic [23:0]       r_mb2, r_ms2;
    logic signed [9:0] r_eb2, r_es2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mb2   <= w_ob.man;
            r_eb2   <= w_ob.ex;
            r_ms2   <= w_os.man;
            r_es2   <= w_os.ex;
            r_fast2 <= r_fast1;
            r_fz2   <= r_fz1;
            r_last2 <= r_last1;
        end
    end

    // ---------------- stage 3: square both ----------------
    logic [47:0]       w_p, w_q;
    logic signed [9:0] w_d;
    logic              w_far;

    assign w_p   = r_mb2 * r_mb2;
    assign w_q   = r_ms2 * r_ms2;
    assign w_d   = r_eb2 - r_es2;
    assign w_far = (w_d > 10'sd28) || (w_d < 10'sd0);

    logic              r_v3, r_fast3, r_last3, r_far3;
    logic [31:0]       r_fz3;
    logic [47:0]       r_p3, r_q3;
    logic [5:0]        r_sh3;
    logic signed [9:0] r_eb3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p3    <= w_p;
            r_q3    <= w_q;
            r_far3  <= w_far;
            r_sh3   <= w_far ? 6'd0 : {w_d[4:0], 1'b0};
            r_eb3   <= r_eb2;
            r_fast3 <= r_fast2;
            r_fz3   <= r_fz2;
            r_last3 <= r_last2;
        end
    end

    // ---------------- stage 4: aligned sum of squares ----------------
    logic [104:0] w_b, w_s;

    // beyond 56 bits apart the smaller square only feeds the sticky bit
    assign w_b = r_far3 ? 105'd1 : ({57'd0, r_q3} << (6'd56 - r_sh3));
    assign w_s = {1'b0, r_p3, 56'd0} + w_b;

    logic              r_v4, r_fast4, r_last4;
    logic [31:0]       r_fz4;
    logic [104:0]      r_s4;
    logic signed [9:0] r_eb4;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (w_en) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s4    <= w_s;
            r_eb4   <= r_eb3;
            r_fast4 <= r_fast3;
            r_fz4   <= r_fz3;
            r_last4 <= r_last3;
        end
    end

    // ---------------- stage 5: round to binary64, make exponent even ----------------
    logic [52:0]        w_mant, w_md;
    logic               w_rnd, w_stk, w_inc;
    logic signed [11:0] w_lo, w_ed0, w_ed, w_e, w_half;
    logic [53:0]        w_mr, w_rad;

    always_comb begin
        if (r_s4[104]) begin
            w_mant = r_s4[104:52];
            w_rnd  = r_s4[51];
            w_stk  = |r_s4[50:0];
            w_lo   = -12'sd4;
        end else if (r_s4[103]) begin
            w_mant = r_s4[103:51];
            w_rnd  = r_s4[50];
            w_stk  = |r_s4[49:0];
            w_lo   = -12'sd5;
        end else begin
            w_mant = r_s4[102:50];
            w_rnd  = r_s4[49];
            w_stk  = |r_s4[48:0];
            w_lo   = -12'sd6;
        end
        w_inc = w_rnd && (w_stk || w_mant[0]);
        w_mr  = {1'b0, w_mant} + {53'd0, w_inc};
        w_ed0 = ($signed({{2{r_eb4[9]}}, r_eb4}) <<< 1) + w_lo;
        if (w_mr[53]) begin
            w_md = w_mr[53:1];
            w_ed = w_ed0 + 12'sd1;
        end else begin
            w_md = w_mr[52:0];
            w_ed = w_ed0;
        end
        if (w_ed[0]) begin
            w_rad = {w_md, 1'b0};
            w_e   = w_ed - 12'sd1;
        end else begin
            w_rad = {1'b0, w_md};
            w_e   = w_ed;
        end
        w_half = (w_e - 12'sd52) >>> 1;
    end

    logic           r_v5;
    logic [53:0]    r_rad5;
    fhu_pkg::t_side r_sd5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5 <= 1'b0;
        end else if (w_en) begin
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad5        <= w_rad;
            r_sd5.last    <= r_last4;
            r_sd5.fast    <= r_fast4;
            r_sd5.fast_z  <= r_fz4;
            r_sd5.half    <= w_half;
        end
    end

    // ---------------- root recurrence ----------------
    logic           w_sq_v;
    logic [52:0]    w_root;
    logic [55:0]    w_rem;
    fhu_pkg::t_side w_sq_sd;

    fhu_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v5),
        .i_rad   (r_rad5),
        .i_side  (r_sd5),
        .o_valid (w_sq_v),
        .o_root  (w_root),
        .o_rem   (w_rem),
        .o_side  (w_sq_sd)
    );

    // ---------------- stage A: round the root ----------------
    logic               w_up;
    logic [53:0]        w_rr;
    logic [52:0]        w_ra;
    logic signed [11:0] w_ha;

    always_comb begin
        w_up = w_rem > {3'b000, w_root};
        w_rr = {1'b0, w_root} + {53'd0, w_up};
        if (w_rr[53]) begin
            w_ra = w_rr[53:1];
            w_ha = w_sq_sd.half + 12'sd1;
        end else begin
            w_ra = w_rr[52:0];
            w_ha = w_sq_sd.half;
        end
    end

    logic               r_va, r_fasta, r_lasta;
    logic [31:0]        r_fza;
    logic [52:0]        r_ra;
    logic signed [11:0] r_ha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (w_en) begin
            r_va <= w_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ra    <= w_ra;
            r_ha    <= w_ha;
            r_fasta <= w_sq_sd.fast;
            r_fza   <= w_sq_sd.fast_z;
            r_lasta <= w_sq_sd.last;
        end
    end

    // ---------------- stage B: pack to binary32 ----------------
    logic signed [11:0] w_fe, w_fe1, w_shw;
    logic [5:0]         w_sh;
    logic [105:0]       w_x;
    logic [31:0]        w_base, w_slow;
    logic               w_g, w_st, w_finc;

    always_comb begin
        w_fe  = r_ha + 12'sd179;
        w_fe1 = w_fe - 12'sd1;
        w_shw = 12'sd30 - w_fe;
        if (w_fe >= 12'sd1) begin
            w_sh   = 6'd29;
            w_base = {1'b0, w_fe1[7:0], 23'd0};
        end else begin
            // subnormal result: shift further right, no exponent
            w_sh   = (w_shw > 12'sd63) ? 6'd63 : w_shw[5:0];
            w_base = '0;
        end
        w_x    = {r_ra, 53'd0} >> w_sh;
        w_g    = w_x[52];
        w_st   = |w_x[51:0];
        w_finc = w_g && (w_st || w_x[53]);
        if (w_fe >= 12'sd255) begin
            w_slow = {1'b0, fhu_pkg::C_INF};
        end else begin
            w_slow = w_base + w_x[84:53] + {31'd0, w_finc};
        end
    end

    logic        r_vb, r_lastb;
    logic [31:0] r_zb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else if (w_en) begin
            r_vb <= r_va;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_zb    <= r_fasta ? r_fza : w_slow;
            r_lastb <= r_lasta;
        end
    end

    // ---------------- output register and skid ----------------
    logic          r_out_v, r_sk_v;
    fhu_pkg::t_out r_out, r_sk;

    assign w_en       = !r_sk_v;
    assign o_stall    = r_sk_v;
    assign w_out_free = !r_out_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
            r_sk_v  <= 1'b0;
        end else if (r_sk_v) begin
            if (w_out_free) begin
                r_out_v <= 1'b1;
                r_sk_v  <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_v <= r_vb;
        end else if (r_vb) begin
            r_sk_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_v) begin
            if (w_out_free) r_out <= r_sk;
        end else if (w_out_free) begin
            r_out <= {r_zb, r_lastb};
        end else begin
            r_sk <= {r_zb, r_lastb};
        end
    end

    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

@@ design/fhu_sqrt.sv @@
// Pipelined restoring integer square root, one result bit per stage.
// Depends on fhu_pkg (t_side, C_SQ_STEPS).
module fhu_sqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [53:0]       i_rad,
    input  fhu_pkg::t_side    i_side,
    output logic              o_valid,
    output logic [52:0]       o_root,
    output logic [55:0]       o_rem,
    output fhu_pkg::t_side    o_side
);

    localparam int N = fhu_pkg::C_SQ_STEPS;

    logic           r_v    [1:N];
    logic [55:0]    r_rem  [1:N];
    logic [52:0]    r_root [1:N];
    fhu_pkg::t_side r_sd   [1:N];
    logic [53:0]    r_rad  [1:26];

    for (genvar j = 0; j < N; j++) begin : g_stage
        logic           p_v;
        logic [55:0]    p_rem;
        logic [52:0]    p_root;
        fhu_pkg::t_side p_sd;
        logic [1:0]     pair;
        logic [55:0]    sh_rem;
        logic [55:0]    trial;

        if (j == 0) begin : g_first
            assign p_v    = i_valid;
            assign p_rem  = '0;
            assign p_root = '0;
            assign p_sd   = i_side;
            assign pair   = i_rad[53:52];
            always_ff @(posedge i_clk) begin
                if (i_en) r_rad[1] <= i_rad;
            end
        end else begin : g_next
            assign p_v    = r_v[j];
            assign p_rem  = r_rem[j];
            assign p_root = r_root[j];
            assign p_sd   = r_sd[j];
            if (j <= 26) begin : g_pair
                assign pair = r_rad[j][2*(26-j)+1 -: 2];
                if (j < 26) begin : g_carry
                    always_ff @(posedge i_clk) begin
                        if (i_en) r_rad[j+1] <= r_rad[j];
                    end
                end
            end else begin : g_zero
                // radicand fully consumed, remaining pairs are zero
                assign pair = 2'b00;
            end
        end

        assign sh_rem = {p_rem[53:0], pair};
        assign trial  = {1'b0, p_root, 2'b01};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j+1] <= 1'b0;
            end else if (i_en) begin
                r_v[j+1] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (sh_rem >= trial) begin
                    r_rem[j+1]  <= sh_rem - trial;
                    r_root[j+1] <= {p_root[51:0], 1'b1};
                end else begin
                    r_rem[j+1]  <= sh_rem;
                    r_root[j+1] <= {p_root[51:0], 1'b0};
                end
                r_sd[j+1] <= p_sd;
            end
        end
    end

    assign o_valid = r_v[N];
    assign o_root  = r_root[N];
    assign o_rem   = r_rem[N];
    assign o_side  = r_sd[N];

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for float_hypot_unit: a bit-level predictor checks each result.
// Depends on fhu_pkg and the design sources; drives random idling and a long output hold.
`timescale 1ns / 1ps

module testbench;

    logic          i_clk;
    logic          i_rst_n;
    logic          i_valid;
    logic          o_stall;
    fhu_pkg::t_in  i_data;
    logic          o_valid;
    logic          i_stall;
    fhu_pkg::t_out o_data;

    fhu_pkg::t_out hypot_queue[$];
    int   error_count;
    int   items_sent;
    int   results_seen;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   hold_cycles;
    int   input_stalls;

    float_hypot_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // binary32 magnitude to binary64 pattern (exact)
    function automatic logic [63:0] flt_to_dbl(input logic [31:0] a);
        logic [10:0] de;
        logic [51:0] df;
        int          p;
        if (a[30:23] == 8'd0) begin
            if (a[22:0] == 23'd0) return 64'd0;
            p = 0;
            for (int i = 0; i < 23; i++) begin
                if (a[i]) p = i;
            end
            de = 11'(p - 149 + 1023);
            df = 52'(64'(a[22:0]) << (52 - p));
        end else begin
            de = 11'(int'(a[30:23]) - 127 + 1023);
            df = {a[22:0], 29'd0};
        end
        return {1'b0, de, df};
    endfunction

    // positive binary64 pattern to binary32, round to nearest even
    function automatic logic [31:0] dbl_to_flt(input logic [63:0] d);
        logic [52:0] m;
        logic [63:0] q;
        logic [63:0] rest;
        logic [63:0] half;
        int          fe;
        int          sh;
        int          base;
        if (d[62:52] == 11'd0) return 32'd0;
        m  = {1'b1, d[51:0]};
        fe = int'(d[62:52]) - 1023 + 127;
        if (fe >= 255) return {1'b0, fhu_pkg::C_INF};
        if (fe >= 1) begin
            sh   = 29;
            base = fe - 1;
        end else begin
            sh   = 30 - fe;
            base = 0;
        end
        if (sh > 60) return 32'd0;
        q    = 64'(m) >> sh;
        rest = 64'(m) & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rest > half || (rest == half && q[0])) q = q + 64'd1;
        q = q + (64'(base) << 23);
        if (q >= 64'h7f800000) return {1'b0, fhu_pkg::C_INF};
        return q[31:0];
    endfunction

    function automatic logic [31:0] hypot_model(input logic [31:0] xb, input logic [31:0] yb);
        logic [31:0] ax, ay, big, lil;
        real         xd, yd, s;
        ax  = {1'b0, xb[30:0]};
        ay  = {1'b0, yb[30:0]};
        big = (ax > ay) ? ax : ay;
        lil = (ax > ay) ? ay : ax;
        if (ax == 0 || ay == 0 || (big - lil) >= {1'b0, fhu_pkg::C_FAR} ||
            big[30:23] == 8'hff) begin
            if (ax == {1'b0, fhu_pkg::C_INF} || ay == {1'b0, fhu_pkg::C_INF})
                return {1'b0, fhu_pkg::C_INF};
            if (ax > {1'b0, fhu_pkg::C_INF}) return xb | fhu_pkg::C_QUIET;
            if (ay > {1'b0, fhu_pkg::C_INF}) return yb | fhu_pkg::C_QUIET;
            s = $bitstoreal(flt_to_dbl(ax)) + $bitstoreal(flt_to_dbl(ay));
            return dbl_to_flt($realtobits(s));
        end
        xd = $bitstoreal(flt_to_dbl(ax));
        yd = $bitstoreal(flt_to_dbl(ay));
        s  = xd * xd + yd * yd;
        return dbl_to_flt($realtobits($sqrt(s)));
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    endtask

    task automatic send_item(input logic [31:0] x, input logic [31:0] y, input logic l);
        fhu_pkg::t_out want;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_data  = '{x_bits: x, y_bits: y, last_item: l};
        forever begin
            @(posedge i_clk);
            if (o_stall) input_stalls++;
            else break;
        end
        want = '{z_bits: hypot_model(x, y), last_out: l};
        hypot_queue.push_back(want);
        items_sent++;
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: v[30:23] = 8'(110 + $urandom_range(30));
            1: v[30:23] = 8'($urandom_range(2) == 0 ? 0 : 8'hff);
            default: ;
        endcase
        return v;
    endfunction

    // second operand with an exponent close to the first: exercises the root path
    function automatic logic [31:0] near_operand(input logic [31:0] x);
        logic [31:0] v;
        int          e;
        v = $urandom;
        e = int'(x[30:23]) + int'($urandom_range(6)) - 3;
        if (e < 0) e = 0;
        if (e > 254) e = 254;
        v[30:23] = 8'(e);
        return v;
    endfunction

    task automatic test_directed();
        send_item(32'h00000000, 32'h00000000, 1'b0);
        send_item(32'h80000000, 32'h00000000, 1'b1);
        send_item(32'h40400000, 32'hc0800000, 1'b0);   // 3, -4
        send_item(32'h3f800000, 32'h3f800000, 1'b0);
        send_item(32'h7f800000, 32'h7fc00001, 1'b0);   // infinity beats NaN
        send_item(32'h7fa00000, 32'hff800000, 1'b0);
        send_item(32'hffa00001, 32'h3f800000, 1'b0);   // signaling NaN in x
        send_item(32'h3f800000, 32'h7f800001, 1'b0);
        send_item(32'hff812345, 32'h7fc00000, 1'b1);   // both NaN: first wins
        send_item(32'h7f7fffff, 32'h7f7fffff, 1'b0);   // overflow to infinity
        send_item(32'h00000001, 32'h00000001, 1'b0);   // subnormals
        send_item(32'h007fffff, 32'h00000003, 1'b0);
        send_item(32'h4c800000, 32'h40000000, 1'b0);   // exactly far apart
        send_item(32'h4c7fffff, 32'h40000000, 1'b0);   // just under
        send_item(32'h7f7fffff, 32'h00000001, 1'b0);
        send_item(32'hffffffff, 32'hffffffff, 1'b1);
        send_item(32'h00800000, 32'h00800000, 1'b0);
        send_item(32'h3f800001, 32'h33800000, 1'b0);
        send_item(32'h7f800000, 32'h7f800000, 1'b1);
        send_item(32'h0000ffff, 32'h80000000, 1'b0);
    endtask

    task automatic test_random(input int count);
        logic [31:0] x, y;
        for (int n = 0; n < count; n++) begin
            x = rand_operand();
            if ($urandom_range(99) < 60) y = near_operand(x);
            else y = rand_operand();
            if ($urandom_range(1)) send_item(x, y, 1'($urandom));
            else send_item(y, x, 1'($urandom));
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_valid = 1'b0;
        @(negedge i_clk);
        hold_cycles = 200;
        test_random(100);
    endtask

    // receiver side: random stall, or a long hold when requested
    always @(negedge i_clk) begin
        if (!i_rst_n) i_stall = 1'b0;
        else if (hold_cycles > 0) begin
            i_stall = 1'b1;
            hold_cycles--;
        end else i_stall = ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        fhu_pkg::t_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (hypot_queue.size() == 0) begin
                report_mismatch("unexpected item", o_data.z_bits, 32'd0);
            end else begin
                want = hypot_queue.pop_front();
                if (o_data.z_bits !== want.z_bits)
                    report_mismatch("z_bits", o_data.z_bits, want.z_bits);
                if (o_data.last_out !== want.last_out)
                    report_mismatch("last_out", 32'(o_data.last_out), 32'(want.last_out));
            end
        end
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        error_count   = 0;
        items_sent    = 0;
        results_seen  = 0;
        input_stalls  = 0;
        hold_cycles   = 0;
        send_idle_pct = 23;
        recv_idle_pct = 62;
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_stall       = 1'b0;
        i_data        = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed();
        test_random(110);
        send_idle_pct = 62;
        recv_idle_pct = 23;
        test_random(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110);
        test_backpressure();
        i_valid = 1'b0;

        while (hypot_queue.size() != 0) @(negedge i_clk);
        repeat (70) @(negedge i_clk);
        if (hypot_queue.size() != 0)
            report_mismatch("items left over", 32'(hypot_queue.size()), 32'd0);

        $display("Sent %0d items, checked %0d results; input held off %0d cycles.",
                 items_sent, results_seen, input_stalls);
        $display("Covered zeros, NaN/infinity, subnormals, overflow, far-apart and root paths.");
        if (error_count == 0) $display("DONE: 0 errors");
        else $display("DONE: errors detected");
        $finish;
    end

endmodule
